// File: hw/rtl/fvn_pkg.sv
`default_nettype none

package fvn_pkg;

    // pipeline stage numbering
    localparam int NSTG     = 15;
    localparam int ST_DIV   = 0;   // reciprocal multiply for the cell index
    localparam int ST_REM   = 1;   // remainder, cell, next cell, blend weight
    localparam int ST_H1    = 2;   // first hash multiply
    localparam int ST_H2    = 3;   // second hash multiply
    localparam int ST_UNIT  = 4;   // 16-bit hash to Q24 unit value
    localparam int ST_DIFF  = 5;   // b - a
    localparam int ST_PROD  = 6;   // (b - a) * s
    localparam int ST_OCT   = 7;   // octave value
    localparam int ST_WGT   = 8;   // octave weights
    localparam int ST_SUM   = 9;   // weighted sum, round, clamp
    localparam int ST_SQ    = 10;  // t * t
    localparam int ST_CUBE  = 11;  // t2 * (3 - 2t)
    localparam int ST_SHAPE = 12;  // round, clamp
    localparam int ST_SCALE = 13;  // * 2000
    localparam int ST_OUT   = 14;  // + 900, output register

    localparam int NOCT   = 3;
    localparam int OCT_FINE   = 0;
    localparam int OCT_MEDIUM = 1;
    localparam int OCT_BROAD  = 2;

    localparam logic [24:0] ONE_Q24 = 25'd16777216;

    localparam logic [31:0] HASH_K1 = 32'd2654435761;
    localparam logic [31:0] HASH_K2 = 32'h9E3779B9;
    localparam logic [31:0] HASH_K3 = 32'd2246822519;
    localparam logic [31:0] HASH_K4 = 32'd3266489917;

    // floor(n * M / 2^k) == floor(n / d) for every 31-bit n
    localparam logic [31:0] DIV7_MAGIC  = 32'd2454267027;  // k = 34
    localparam logic [31:0] DIV23_MAGIC = 32'd2987803337;  // k = 36

    localparam logic [23:0] W_BROAD  = 24'd10401874;
    localparam logic [23:0] W_MEDIUM = 24'd4362076;
    localparam logic [23:0] W_FINE   = 24'd2013266;

    localparam logic [23:0] BASE_Q12   = 24'd3686400;
    localparam logic [23:0] HEIGHT_MAX = 24'd11878400;
    localparam logic [10:0] SPAN       = 11'd2000;

    function automatic logic [31:0] hash_salt(input logic [31:0] salt);
        logic [31:0] x;
        x = salt + HASH_K2;
        return x * HASH_K3;
    endfunction

    localparam logic [31:0] HS_FINE   = hash_salt(32'd11);
    localparam logic [31:0] HS_MEDIUM = hash_salt(32'd23);
    localparam logic [31:0] HS_BROAD  = hash_salt(32'd47);
    localparam logic [NOCT-1:0][31:0] SALT_MIX = {HS_BROAD, HS_MEDIUM, HS_FINE};

    // smoothstep in Q24; only ever evaluated on constants (table build)
    function automatic logic [24:0] smooth_q24(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] k;
        logic [63:0] s;
        t2 = (t * t + 64'd8388608) >> 24;
        k  = 64'd50331648 - (t << 1);
        s  = (t2 * k + 64'd8388608) >> 24;
        if (s > 64'd16777216) begin
            s = 64'd16777216;
        end
        return s[24:0];
    endfunction

    // blend weight from the position inside the cell, per period
    function automatic logic [24:0] s_lut2(input logic r);
        logic [24:0] s;
        s = '0;
        for (int i = 0; i < 2; i++) begin
            if (r == 1'(i)) begin
                s = smooth_q24((64'(i) * 64'd16777216 + 64'd1) / 64'd2);
            end
        end
        return s;
    endfunction

    function automatic logic [24:0] s_lut7(input logic [2:0] r);
        logic [24:0] s;
        s = '0;
        for (int i = 0; i < 7; i++) begin
            if (r == 3'(i)) begin
                s = smooth_q24((64'(i) * 64'd16777216 + 64'd3) / 64'd7);
            end
        end
        return s;
    endfunction

    function automatic logic [24:0] s_lut23(input logic [4:0] r);
        logic [24:0] s;
        s = '0;
        for (int i = 0; i < 23; i++) begin
            if (r == 5'(i)) begin
                s = smooth_q24((64'(i) * 64'd16777216 + 64'd11) / 64'd23);
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fractal_value_noise_height_unit.sv
// Throughput: one request per cycle while the output is not stalled; the pipeline has 15 stages.
// A stalled output holds its stage; bubbles further up are squeezed out while it waits.
// Reset: synchronous, active low on i_rst_n; clears every stage valid bit, data is left as is.
`default_nettype none

module fractal_value_noise_height_unit import fvn_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_boundary_index,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [23:0]             o_floor_height
);

    // ------------------------------------------------------------------
    // Flow control. Every stage has a valid bit; a stage loads when it is
    // empty or when the stage after it loads too. So a stalled result only
    // holds the stages that are full behind it.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] rdy;

    assign rdy[NSTG-1] = !r_vld[NSTG-1] || i_ready;

    genvar g;
    generate
        for (g = 0; g < NSTG - 1; g++) begin : g_rdy
            assign rdy[g] = !r_vld[g] || rdy[g + 1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (rdy[i]) begin
                    r_vld[i] <= r_vld[i - 1];
                end
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NSTG-1];

    // ------------------------------------------------------------------
    // Cell split: floor division by 2, 7 and 23 (shift, reciprocal
    // multiplies), then remainder, cell, next cell and blend weight.
    // ------------------------------------------------------------------
    logic [NOCT-1:0][31:0] cell_num;
    logic [NOCT-1:0][31:0] next_cell;
    logic [NOCT-1:0][24:0] s_rem;

    fvn_celldiv u_celldiv (
        .i_clk   (i_clk),
        .i_en    (rdy[ST_REM:ST_DIV]),
        .i_index (i_boundary_index),
        .o_cell  (cell_num),
        .o_next  (next_cell),
        .o_s     (s_rem)
    );

    // blend weight rides along while the two hashes are worked out
    logic [NOCT-1:0][24:0] r_s_h1;
    logic [NOCT-1:0][24:0] r_s_h2;
    logic [NOCT-1:0][24:0] r_s_unit;

    always_ff @(posedge i_clk) begin
        if (rdy[ST_H1]) begin
            r_s_h1 <= s_rem;
        end
        if (rdy[ST_H2]) begin
            r_s_h2 <= r_s_h1;
        end
        if (rdy[ST_UNIT]) begin
            r_s_unit <= r_s_h2;
        end
    end

    // ------------------------------------------------------------------
    // Per octave: hash cell and next cell (multiply/xor-shift mix,
    // 32-bit wrap), scale to Q24, then blend.
    // ------------------------------------------------------------------
    logic [NOCT-1:0][24:0] unit_a;
    logic [NOCT-1:0][24:0] unit_b;
    logic [NOCT-1:0][24:0] oct;

    generate
        for (g = 0; g < NOCT; g++) begin : g_oct
            fvn_hash u_hash_cell (
                .i_clk      (i_clk),
                .i_en       (rdy[ST_UNIT:ST_H1]),
                .i_cell     (cell_num[g]),
                .i_salt_mix (SALT_MIX[g]),
                .o_unit     (unit_a[g])
            );

            fvn_hash u_hash_next (
                .i_clk      (i_clk),
                .i_en       (rdy[ST_UNIT:ST_H1]),
                .i_cell     (next_cell[g]),
                .i_salt_mix (SALT_MIX[g]),
                .o_unit     (unit_b[g])
            );

            fvn_blend u_blend (
                .i_clk (i_clk),
                .i_en  (rdy[ST_OCT:ST_DIFF]),
                .i_a   (unit_a[g]),
                .i_b   (unit_b[g]),
                .i_s   (r_s_unit[g]),
                .o_oct (oct[g])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Weighted octave sum, second smoothstep, map to 900 + 2000 * v.
    // Its last register is the output register.
    // ------------------------------------------------------------------
    fvn_shape u_shape (
        .i_clk    (i_clk),
        .i_en     (rdy[ST_OUT:ST_WGT]),
        .i_oct    (oct),
        .o_height (o_floor_height)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_floor_height >= BASE_Q12 && o_floor_height <= HEIGHT_MAX))
        else $error("floor height out of range");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_ready) |-> !o_ready)
        else $error("full pipeline took a request while stalled");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[ST_DIV])
        else $error("accepted request did not enter the first stage");

endmodule

`default_nettype wire

// File: hw/rtl/fvn_celldiv.sv
`default_nettype none

module fvn_celldiv import fvn_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic [1:0]             i_en,
    input  wire logic signed [31:0]     i_index,
    output logic [NOCT-1:0][31:0]       o_cell,
    output logic [NOCT-1:0][31:0]       o_next,
    output logic [NOCT-1:0][24:0]       o_s
);

    // negative index: floor(x/d) = ~floor(~x/d), remainder mirrored
    logic [30:0] mag;
    logic [62:0] prod7;
    logic [62:0] prod23;

    logic        r_neg;
    logic [4:0]  r_mlo;
    logic [29:0] r_q2;
    logic [28:0] r_q7;
    logic [26:0] r_q23;

    assign mag    = i_index[31] ? ~i_index[30:0] : i_index[30:0];
    assign prod7  = 63'(mag) * 63'(DIV7_MAGIC);
    assign prod23 = 63'(mag) * 63'(DIV23_MAGIC);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_neg <= i_index[31];
            r_mlo <= mag[4:0];
            r_q2  <= mag[30:1];
            r_q7  <= prod7[62:34];
            r_q23 <= prod23[62:36];
        end
    end

    logic [4:0]  rm7;
    logic [4:0]  rm23;
    logic        r2;
    logic [2:0]  r7;
    logic [4:0]  r23;
    logic [31:0] qx2;
    logic [31:0] qx7;
    logic [31:0] qx23;

    // remainder is below 32, so low bits suffice
    assign rm7  = r_mlo - 5'(r_q7[4:0] * 5'd7);
    assign rm23 = r_mlo - 5'(r_q23[4:0] * 5'd23);
    assign r2   = r_neg ? ~r_mlo[0] : r_mlo[0];
    assign r7   = r_neg ? (3'd6 - rm7[2:0]) : rm7[2:0];
    assign r23  = r_neg ? (5'd22 - rm23) : rm23;
    assign qx2  = {2'b00, r_q2};
    assign qx7  = {3'b000, r_q7};
    assign qx23 = {5'b00000, r_q23};

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            o_cell[OCT_FINE]   <= r_neg ? ~qx2  : qx2;
            o_cell[OCT_MEDIUM] <= r_neg ? ~qx7  : qx7;
            o_cell[OCT_BROAD]  <= r_neg ? ~qx23 : qx23;
            o_next[OCT_FINE]   <= r_neg ? (32'd0 - qx2)  : (qx2 + 32'd1);
            o_next[OCT_MEDIUM] <= r_neg ? (32'd0 - qx7)  : (qx7 + 32'd1);
            o_next[OCT_BROAD]  <= r_neg ? (32'd0 - qx23) : (qx23 + 32'd1);
            o_s[OCT_FINE]      <= s_lut2(r2);
            o_s[OCT_MEDIUM]    <= s_lut7(r7);
            o_s[OCT_BROAD]     <= s_lut23(r23);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fvn_hash.sv
`default_nettype none

module fvn_hash import fvn_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic [2:0]  i_en,
    input  wire logic [31:0] i_cell,
    input  wire logic [31:0] i_salt_mix,
    output logic [24:0]      o_unit
);

    logic [31:0] r_h1;
    logic [31:0] r_h2;
    logic [31:0] sh;
    logic [15:0] v;
    logic [24:0] x;
    logic [16:0] lo_sum;
    logic        carry;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_h1 <= (i_cell * HASH_K1) ^ i_salt_mix;
        end
    end

    assign sh = r_h1 ^ (r_h1 >> 13);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_h2 <= sh * HASH_K4;
        end
    end

    // (v * 2^24 + 32767) / 65535 = v*256 + x/65535, x = v*256 + 32767
    assign v      = r_h2[15:0] ^ r_h2[31:16];
    assign x      = 25'({v, 8'h00}) + 25'd32767;
    assign lo_sum = 17'(x[24:16]) + 17'(x[15:0]);
    assign carry  = (lo_sum >= 17'd65535);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_unit <= 25'({v, 8'h00}) + 25'(x[24:16]) + 25'(carry);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fvn_blend.sv
`default_nettype none

module fvn_blend import fvn_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic [2:0]  i_en,
    input  wire logic [24:0] i_a,
    input  wire logic [24:0] i_b,
    input  wire logic [24:0] i_s,
    output logic [24:0]      o_oct
);

    // a*(1-s) + b*s == a + (b-a)*s, rounded
    logic signed [25:0] r_diff;
    logic [24:0]        r_a;
    logic [24:0]        r_s;
    logic signed [51:0] r_prod;
    logic [24:0]        r_a2;
    logic [27:0]        osum;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_diff <= signed'({1'b0, i_b}) - signed'({1'b0, i_a});
            r_a    <= i_a;
            r_s    <= i_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_prod <= 52'(r_diff) * 52'(signed'({1'b0, r_s}));
            r_a2   <= r_a;
        end
    end

    assign osum = 28'(r_a2) + 28'(r_prod[51:24]) + 28'(r_prod[23]);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_oct <= osum[24:0];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fvn_shape.sv
`default_nettype none

module fvn_shape import fvn_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic [6:0]            i_en,
    input  wire logic [NOCT-1:0][24:0] i_oct,
    output logic [23:0]                o_height
);

    logic [48:0] r_pb;
    logic [48:0] r_pm;
    logic [48:0] r_pf;
    logic [48:0] wsum;
    logic [25:0] tr;
    logic [24:0] r_t;
    logic [48:0] r_tsq;
    logic [25:0] r_k;
    logic [25:0] t2;
    logic [50:0] r_p2;
    logic [27:0] sr;
    logic [24:0] r_s;
    logic [35:0] r_ps;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pb <= 49'(i_oct[OCT_BROAD])  * 49'(W_BROAD);
            r_pm <= 49'(i_oct[OCT_MEDIUM]) * 49'(W_MEDIUM);
            r_pf <= 49'(i_oct[OCT_FINE])   * 49'(W_FINE);
        end
    end

    // weights sum to exactly 1.0, so the sum stays below 2^49
    assign wsum = r_pb + r_pm + r_pf;
    assign tr   = 26'(wsum[48:24]) + 26'(wsum[23]);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_t <= (tr > 26'(ONE_Q24)) ? ONE_Q24 : tr[24:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_tsq <= 49'(r_t) * 49'(r_t);
            r_k   <= 26'd50331648 - {r_t, 1'b0};
        end
    end

    assign t2 = 26'(r_tsq[48:24]) + 26'(r_tsq[23]);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_p2 <= 51'(t2[24:0]) * 51'(r_k);
        end
    end

    assign sr = 28'(r_p2[50:24]) + 28'(r_p2[23]);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s <= (sr > 28'(ONE_Q24)) ? ONE_Q24 : sr[24:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_ps <= 36'(r_s) * 36'(SPAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            o_height <= BASE_Q12 + 24'((r_ps + 36'd2048) >> 12);
        end
    end

endmodule

`default_nettype wire

// File: sim/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Q24 unit scale and the hash / weight constants of the height function
    localparam bit [63:0] UNIT_ONE  = 64'd16777216;
    localparam bit [63:0] UNIT_HALF = 64'd8388608;
    localparam bit [31:0] MIX_MUL_A = 32'd2654435761;
    localparam bit [31:0] MIX_GOLD  = 32'h9E3779B9;
    localparam bit [31:0] MIX_MUL_B = 32'd2246822519;
    localparam bit [31:0] MIX_MUL_C = 32'd3266489917;
    localparam bit [63:0] WT_BROAD  = 64'd10401874;
    localparam bit [63:0] WT_MEDIUM = 64'd4362076;
    localparam bit [63:0] WT_FINE   = 64'd2013266;
    localparam bit [63:0] FLOOR_BASE = 64'd3686400;   // 900.0 in Q12
    localparam bit [63:0] FLOOR_SPAN = 64'd2000;

    localparam int RANDOM_PER_PHASE = 150;
    localparam int SETTLE_CYCLES    = 20;
    localparam int REPORT_LIMIT     = 10;

    // flow-control phases; each sets how often the request side idles
    // and how often the result side stalls
    typedef enum int {
        PH_STEADY,
        PH_SPARSE_SEND,
        PH_SLOW_DRAIN,
        PH_BOTH_IDLE
    } flow_phase_e;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_boundary_index = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [23:0]        o_floor_height;

    flow_phase_e phase = PH_STEADY;

    logic [23:0] pending_heights[$];    // expected heights, oldest first
    int          requests_sent = 0;
    int          heights_checked = 0;
    int          mismatches = 0;

    fractal_value_noise_height_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_boundary_index (i_boundary_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_floor_height   (o_floor_height)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Height predictor
    // ------------------------------------------------------------------

    // 32-bit wrapping multiply / xor-shift mix of a cell number and a salt
    function automatic bit [31:0] cell_hash(input bit [31:0] cell_bits, input bit [31:0] salt);
        bit [31:0] h;
        h = (cell_bits * MIX_MUL_A) ^ ((salt + MIX_GOLD) * MIX_MUL_B);
        h = h ^ (h >> 13);
        h = h * MIX_MUL_C;
        h = h ^ (h >> 16);
        return h;
    endfunction

    // low 16 hash bits scaled to [0,1] in Q24, rounded to nearest
    function automatic bit [63:0] cell_level(input longint cell_num, input bit [31:0] salt);
        bit [63:0] v16;
        v16 = 64'(cell_hash(32'(cell_num), salt) & 32'hFFFF);
        return (v16 * UNIT_ONE + 64'd32767) / 64'd65535;
    endfunction

    // 3t^2 - 2t^3 in Q24, clamped to one
    function automatic bit [63:0] ease_q24(input bit [63:0] t);
        bit [63:0] t2;
        bit [63:0] k;
        bit [63:0] s;
        t2 = (t * t + UNIT_HALF) >> 24;
        k  = 64'd3 * UNIT_ONE - 64'd2 * t;
        s  = (t2 * k + UNIT_HALF) >> 24;
        return (s > UNIT_ONE) ? UNIT_ONE : s;
    endfunction

    // one octave: floor-divide into cells, blend neighbor levels
    function automatic bit [63:0] octave_level(input longint idx, input longint period,
                                               input bit [31:0] salt);
        longint    cell_num;
        longint    offset;
        bit [63:0] t;
        bit [63:0] lo;
        bit [63:0] hi;
        bit [63:0] s;
        cell_num = idx / period;
        offset   = idx - cell_num * period;
        if (offset < 0) begin       // round the cell toward minus infinity
            cell_num = cell_num - 1;
            offset   = offset + period;
        end
        t  = (64'(offset) * UNIT_ONE + 64'(period / 2)) / 64'(period);
        lo = cell_level(cell_num, salt);
        hi = cell_level(cell_num + 1, salt);
        s  = ease_q24(t);
        return (lo * (UNIT_ONE - s) + hi * s + UNIT_HALF) >> 24;
    endfunction

    function automatic logic [23:0] predict_floor_height(input logic signed [31:0] index);
        longint    idx;
        bit [63:0] fine;
        bit [63:0] mid;
        bit [63:0] broad;
        bit [63:0] mixed;
        bit [63:0] shaped;
        idx    = longint'(index);
        fine   = octave_level(idx, 2, 32'd11);
        mid    = octave_level(idx, 7, 32'd23);
        broad  = octave_level(idx, 23, 32'd47);
        mixed  = (broad * WT_BROAD + mid * WT_MEDIUM + fine * WT_FINE + UNIT_HALF) >> 24;
        if (mixed > UNIT_ONE) begin
            mixed = UNIT_ONE;
        end
        shaped = ease_q24(mixed);
        return 24'(FLOOR_BASE + ((shaped * FLOOR_SPAN + 64'd2048) >> 12));
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Directed indices: zero and its neighbors, both ends of the 32-bit range,
    // cell edges of each period on both signs, multiples of 322 (all three
    // cell grids line up there), and alternating bit patterns.
    localparam int DIRECTED_COUNT = 25;
    localparam logic [31:0] DIRECTED_INDEX [DIRECTED_COUNT] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h8000_0001, 32'h7FFF_FFFE, 32'hFFFF_FFFE, 32'h0000_0002,
        32'd6, 32'd7, -32'sd7, -32'sd8,
        32'd22, 32'd23, -32'sd23, -32'sd24, 32'd45, 32'd46,
        32'd322, -32'sd322, 32'h4000_0000, 32'hC000_0000,
        32'h5555_5555, 32'hAAAA_AAAA
    };

    function automatic int unsigned send_idle_pct(input flow_phase_e ph);
        case (ph)
            PH_SPARSE_SEND: return 82;
            PH_BOTH_IDLE:   return 30;
            default:        return 0;
        endcase
    endfunction

    function automatic int unsigned drain_stall_pct(input flow_phase_e ph);
        case (ph)
            PH_SLOW_DRAIN: return 82;
            PH_BOTH_IDLE:  return 30;
            default:       return 0;
        endcase
    endfunction

    // random index: full-range in 45 of 100 picks, plus small indices, the range ends,
    // and points right around shared cell edges
    function automatic logic [31:0] pick_index();
        int unsigned sel;
        int          k;
        sel = $urandom_range(99);
        if (sel < 45) begin
            return $urandom;
        end else if (sel < 65) begin
            return 32'(int'($urandom_range(2000)) - 1000);
        end else if (sel < 80) begin
            if ($urandom_range(1) == 0) begin
                return 32'h7FFF_FFFF - $urandom_range(400);
            end
            return 32'h8000_0000 + $urandom_range(400);
        end
        k = int'($urandom_range(13_000_000)) - 6_500_000;
        return 32'(k * 322 + int'($urandom_range(6)) - 3);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    // At most one assignment to i_valid per falling edge.
    task automatic send_request(input logic [31:0] index);
        while ($urandom_range(99) < send_idle_pct(phase)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_boundary_index <= index;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        pending_heights.push_back(predict_floor_height(index));
        requests_sent++;
        @(negedge i_clk);
    endtask

    // result side back-pressure, changed at the falling edge
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= drain_stall_pct(phase));
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        logic [23:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_heights.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: height %0d with no request outstanding",
                             $realtime, o_floor_height);
                end
            end else begin
                want = pending_heights.pop_front();
                heights_checked++;
                if (o_floor_height !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: floor_height expected %0d got %0d",
                                 $realtime, want, o_floor_height);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed requests at full rate
        phase = PH_STEADY;
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_request(DIRECTED_INDEX[i]);
        end

        // random requests under each flow-control pattern
        for (int p = PH_STEADY; p <= PH_BOTH_IDLE; p++) begin
            phase = flow_phase_e'(p);
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                send_request(pick_index());
            end
        end
        i_valid <= 1'b0;
        phase = PH_STEADY;

        wait (pending_heights.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d boundary indices (%0d directed) through steady, sparse, stalled",
                 requests_sent, DIRECTED_COUNT);
        $display("and mixed flow control; %0d heights compared, %0d mismatches",
                 heights_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run of ~625 requests
    initial begin
        #3_000_000;
        $display("Timeout with %0d heights still expected", pending_heights.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// File: fractal_value_noise_height_unit.f
hw/rtl/fvn_pkg.sv
hw/rtl/fvn_celldiv.sv
hw/rtl/fvn_hash.sv
hw/rtl/fvn_blend.sv
hw/rtl/fvn_shape.sv
hw/rtl/fractal_value_noise_height_unit.sv
sim/testbench.sv
